// ===== hdl/rrwl_pkg.sv =====
// Package for the reentrant reader-writer lock table.
// Types, status codes and operation codes shared by the front and back parts.
package rrwl_pkg;
    localparam int unsigned OpW    = 2;
    localparam int unsigned IdxW   = 6;
    localparam int unsigned OwnW   = 8;
    localparam int unsigned CntW   = 16;
    localparam int unsigned StW    = 3;

    typedef enum logic [OpW-1:0] {
        OP_ACQ_RD = 2'd0,
        OP_ACQ_WR = 2'd1,
        OP_REL_RD = 2'd2,
        OP_REL_WR = 2'd3
    } t_op;

    localparam logic [StW-1:0] ST_GRANTED   = 3'd0;
    localparam logic [StW-1:0] ST_CONFLICT  = 3'd1;
    localparam logic [StW-1:0] ST_NOROOM    = 3'd2;
    localparam logic [StW-1:0] ST_RELEASED  = 3'd3;
    localparam logic [StW-1:0] ST_NOTHOLDER = 3'd4;

    localparam logic [CntW-1:0] CNT_MAX = '1;

    typedef struct packed {
        t_op             op;
        logic [IdxW-1:0] idx;
        logic [OwnW-1:0] who;
        logic            oor;   // index beyond table: answer without touching state
    } t_req;

    typedef struct packed {
        logic [StW-1:0]  status;
        logic [CntW-1:0] hold;
        logic            idle;
    } t_res;
endpackage

// ===== hdl/reentrant_rw_lock_table_unit.sv =====
// Reentrant reader-writer lock table, top level.
// Path: front queue, registered row read, then row write-back and result queue.
// The back part takes no new request until the read-modify-write of one lock row is done.
// Reset (synchronous, active low) empties both queues and marks every row as free.
// Uses rrwl_pkg, rrwl_front, rrwl_back.
module reentrant_rw_lock_table_unit
    import rrwl_pkg::*;
#(
    parameter int unsigned LOCKS   = 64,
    parameter int unsigned READERS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  logic [OpW-1:0]  i_operation,
    input  logic [IdxW-1:0] i_lock_index,
    input  logic [OwnW-1:0] i_owner_id,
    output logic            empty,
    input  logic            pop,
    output logic [StW-1:0]  o_status,
    output logic [CntW-1:0] o_hold_count,
    output logic            o_now_idle
);
    logic w_rv, w_take;
    t_req w_req;

    rrwl_front #(.LOCKS(LOCKS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_operation, .i_lock_index, .i_owner_id,
        .o_req_valid(w_rv), .o_req(w_req), .i_req_take(w_take)
    );

    rrwl_back #(.LOCKS(LOCKS), .READERS(READERS)) u_back (
        .i_clk, .i_rst_n, .i_req_valid(w_rv), .i_req(w_req), .o_req_take(w_take),
        .o_empty(empty), .i_pop(pop), .o_status, .o_hold_count, .o_now_idle
    );

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= ST_NOTHOLDER)) else $error("bad status");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_rv) else $error("take without request");
    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_GRANTED) |-> (o_hold_count != '0 && !o_now_idle))
        else $error("grant with zero count");
endmodule

// ===== hdl/rrwl_front.sv =====
// Front part: takes requests, classifies range and queues them for the back part.
// Uses rrwl_pkg.
module rrwl_front
    import rrwl_pkg::*;
#(
    parameter int unsigned LOCKS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [OpW-1:0]  i_operation,
    input  logic [IdxW-1:0] i_lock_index,
    input  logic [OwnW-1:0] i_owner_id,
    output logic            o_req_valid,
    output t_req            o_req,
    input  logic            i_req_take
);
    // two-entry queue
    t_req   r_q [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req   w_in;
    logic   w_push, w_pop;

    always_comb begin
        w_in.op  = t_op'(i_operation);
        w_in.idx = i_lock_index;
        w_in.who = i_owner_id;
        w_in.oor = ({1'b0, i_lock_index} >= (IdxW+1)'(LOCKS)) && (LOCKS < 64);
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_req_take && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// ===== hdl/rrwl_back.sv =====
// Back part: read-modify-write of one lock row, result queue toward the caller.
// Uses rrwl_pkg. Row memory plus one valid bit per row (cleared at reset).
module rrwl_back
    import rrwl_pkg::*;
#(
    parameter int unsigned LOCKS   = 64,
    parameter int unsigned READERS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  t_req            i_req,
    output logic            o_req_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [StW-1:0]  o_status,
    output logic [CntW-1:0] o_hold_count,
    output logic            o_now_idle
);
    localparam int unsigned RowW = OwnW + CntW + READERS*(OwnW+CntW);
    localparam int unsigned RIW  = $clog2(READERS+1);

    typedef struct packed {
        logic [OwnW-1:0]               wown;
        logic [CntW-1:0]               wcnt;
        logic [READERS-1:0][OwnW-1:0]  rown;
        logic [READERS-1:0][CntW-1:0]  rcnt;
    } t_row;

    typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} t_st;

    logic [RowW-1:0] r_mem [LOCKS];
    logic [LOCKS-1:0] r_vld;
    logic [RowW-1:0] r_rd;
    logic            r_rdv;
    t_st             r_st;
    t_req            r_req;
    t_res            r_oq [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_oc;

    t_row   w_row, w_new;
    t_res   w_res;
    logic   w_wr, w_start, w_done, w_pop;
    logic [IdxW-1:0] w_ra;

    assign w_ra    = i_req.idx;
    // nothing in flight while idle: one free result slot is enough
    assign w_start = (r_st == S_IDLE) && i_req_valid && (r_oc != 2'd2);
    assign o_req_take = w_start;
    assign w_done  = (r_st == S_EXEC);
    assign w_pop   = i_pop && !o_empty;
    assign o_empty = (r_oc == 2'd0);
    assign o_status     = r_oq[r_rp].status;
    assign o_hold_count = r_oq[r_rp].hold;
    assign o_now_idle   = r_oq[r_rp].idle;

    always_comb begin
        w_row = r_rdv ? t_row'(r_rd) : '0;
    end

    // per-slot match and free flags (slots compared in parallel)
    logic [READERS-1:0] w_free, w_mine, w_hit;
    logic [RIW-1:0] w_fi, w_ai, w_ni; // holder slot, acquire slot, valid count
    logic w_fv, w_av;
    logic [CntW-1:0] w_cnt;
    logic have_w, mine_w;

    always_comb begin
        w_fv = 1'b0; w_fi = '0; w_av = 1'b0; w_ai = '0; w_ni = RIW'(READERS);
        for (int k = 0; k < READERS; k++) begin
            w_free[k] = (w_row.rcnt[k] == '0);
            w_mine[k] = (w_row.rown[k] == r_req.who);
        end
        for (int k = READERS-1; k >= 0; k--) begin
            if (w_free[k]) w_ni = RIW'(k);
        end
        for (int k = 0; k < READERS; k++) begin
            w_hit[k] = (RIW'(k) < w_ni) && w_mine[k];
        end
        for (int k = READERS-1; k >= 0; k--) begin
            if (w_hit[k]) begin w_fv = 1'b1; w_fi = RIW'(k); end
            if (w_free[k] || w_mine[k]) begin w_av = 1'b1; w_ai = RIW'(k); end
        end
    end

    always_comb begin
        have_w = (w_row.wcnt != '0);
        mine_w = have_w && (w_row.wown == r_req.who);
        w_new  = w_row;
        w_res.status = ST_NOROOM;
        w_res.hold   = '0;
        w_wr   = 1'b0;
        w_cnt  = '0;
        case (r_req.op)
            OP_ACQ_WR: begin
                if (mine_w) begin
                    if (w_row.wcnt == CNT_MAX) w_res.status = ST_NOROOM;
                    else begin
                        w_new.wcnt = w_row.wcnt + 1'b1;
                        w_res.status = ST_GRANTED; w_wr = 1'b1;
                    end
                    w_res.hold = w_new.wcnt;
                end else if (!have_w && (w_free[0] || (w_mine[0] &&
                             (READERS < 2 || w_free[READERS > 1 ? 1 : 0])))) begin
                    w_new.wown = r_req.who; w_new.wcnt = CntW'(1);
                    w_res.status = ST_GRANTED; w_res.hold = CntW'(1); w_wr = 1'b1;
                end else w_res.status = ST_CONFLICT;
            end
            OP_ACQ_RD: begin
                if (have_w && !mine_w) begin
                    w_res.status = ST_CONFLICT;
                    w_res.hold = w_fv ? w_row.rcnt[w_fi] : '0;
                end else if (!w_av) w_res.status = ST_NOROOM;
                else if (w_row.rcnt[w_ai] == CNT_MAX) begin
                    w_res.status = ST_NOROOM; w_res.hold = CNT_MAX;
                end else begin
                    w_new.rown[w_ai] = r_req.who;
                    w_new.rcnt[w_ai] = w_row.rcnt[w_ai] + 1'b1;
                    w_res.status = ST_GRANTED; w_res.hold = w_new.rcnt[w_ai];
                    w_wr = 1'b1;
                end
            end
            OP_REL_RD: begin
                if (!w_fv) w_res.status = ST_NOTHOLDER;
                else begin
                    w_cnt = w_row.rcnt[w_fi] - 1'b1;
                    w_new.rcnt[w_fi] = w_cnt;
                    w_res.status = ST_RELEASED; w_res.hold = w_cnt; w_wr = 1'b1;
                    // last valid reader fills the gap
                    if (w_cnt == '0 && w_ni != w_fi + 1'b1) begin
                        w_new.rown[w_fi] = w_row.rown[w_ni - 1'b1];
                        w_new.rcnt[w_fi] = w_row.rcnt[w_ni - 1'b1];
                        w_new.rcnt[w_ni - 1'b1] = '0;
                    end
                end
            end
            OP_REL_WR: begin
                if (!mine_w) w_res.status = ST_NOTHOLDER;
                else begin
                    w_new.wcnt = w_row.wcnt - 1'b1;
                    w_res.status = ST_RELEASED; w_res.hold = w_new.wcnt; w_wr = 1'b1;
                end
            end
            default: w_res.status = ST_NOROOM;
        endcase
        w_res.idle = (w_new.wcnt == '0) && (w_new.rcnt[0] == '0);
        if (r_req.oor) begin
            w_res.status = ST_NOROOM; w_res.hold = '0; w_res.idle = 1'b1; w_wr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rd  <= r_mem[w_ra];
            r_rdv <= r_vld[w_ra];
            r_req <= i_req;
        end
        if (w_done && w_wr) r_mem[r_req.idx] <= RowW'(w_new);
        if (w_done) r_oq[r_wp] <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_vld <= '0;
            r_wp <= 1'b0; r_rp <= 1'b0; r_oc <= 2'd0;
        end else begin
            case (r_st)
                S_IDLE:  if (w_start) r_st <= S_EXEC;
                S_EXEC:  r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
            if (w_done && w_wr) r_vld[r_req.idx] <= 1'b1;
            if (w_done) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_oc <= r_oc + 2'(w_done) - 2'(w_pop);
        end
    end
endmodule
